@@ design/xbd_pkg.sv @@
// Shared types, constants and helpers for the XTEA block decrypt pipeline.
package xbd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = 2;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // Key words after reset
    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h1234_5678;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'hAABB_CCDD;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'h1010_1010;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'hF00D_BABE;

    // Register indexes on the configuration port
    localparam logic [KEY_IDX_W-1:0] REG_KEY0 = 2'd0;
    localparam logic [KEY_IDX_W-1:0] REG_KEY1 = 2'd1;
    localparam logic [KEY_IDX_W-1:0] REG_KEY2 = 2'd2;
    localparam logic [KEY_IDX_W-1:0] REG_KEY3 = 2'd3;

    // Block state carried from cell to cell
    typedef struct packed {
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v0;
    } words_t;

    // Running sum after n rounds remain: delta * n modulo 2^32
    function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

@@ design/xbd_cell.sv @@
// One half-round cell of the XTEA decrypt chain, with its own stage register.
module xbd_cell #(
    parameter logic [31:0] SUM       = 32'h0,
    parameter bit          UPDATE_V0 = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  xbd_pkg::words_t      in_words,
    input  logic [31:0]          key_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output xbd_pkg::words_t      out_words
);

    logic            valid_reg;
    xbd_pkg::words_t words_reg;
    xbd_pkg::words_t words_next;
    logic [31:0]     src;
    logic [31:0]     mix;
    logic [31:0]     keyed;

    // Mix the source word and subtract it from the other half
    always_comb
    begin
        words_next = in_words;
        src        = UPDATE_V0 ? in_words.v1 : in_words.v0;
        mix        = ((src << 4) ^ (src >> 5)) + src;
        keyed      = SUM + key_word;
        if (UPDATE_V0)
        begin
            words_next.v0 = in_words.v0 - (mix ^ keyed);
        end
        else
        begin
            words_next.v1 = in_words.v1 - (mix ^ keyed);
        end
    end

    // Take a new item when empty or when the neighbor takes ours
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload only with an item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            words_reg <= words_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_words = words_reg;

endmodule

@@ design/xtea_block_decrypt_unit.sv @@
// Top level: XTEA block decrypt as a chain of half-round cells.
//
//  channel   direction  handshake              payload
//  s_axis    in         s_tvalid / s_tready    s_tdata: cipher_high, cipher_low
//  m_axis    out        m_tvalid / m_tready    m_tdata: plain_high, plain_low
//  config    in         cfg_we                 cfg_index, cfg_data (key words)
//
// Each item passes 2*ROUNDS cells (64 at the default), one register each;
// throughput one item per cycle while m_tready is high.
// Every cell has its own valid bit; a stalled output stops only the cells
// behind it that are full, so bubbles close up while m_tready is low.
// The last cell's register is the output register.
// Reset empties the chain and loads the default key; key writes are taken any time.
module xtea_block_decrypt_unit #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] cipher_high, [63:32] cipher_low
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] plain_high, [63:32] plain_low
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned CELLS = 2 * ROUNDS;

    logic [31:0]     key_reg [xbd_pkg::KEY_WORDS];
    logic            valid_w [CELLS+1];
    logic            ready_w [CELLS+1];
    xbd_pkg::words_t words_w [CELLS+1];
    logic [CELLS-1:0] cell_valid;

    // Hold the key words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= xbd_pkg::KEY0_RESET;
            key_reg[1] <= xbd_pkg::KEY1_RESET;
            key_reg[2] <= xbd_pkg::KEY2_RESET;
            key_reg[3] <= xbd_pkg::KEY3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xbd_pkg::REG_KEY0: key_reg[0] <= cfg_data;
                xbd_pkg::REG_KEY1: key_reg[1] <= cfg_data;
                xbd_pkg::REG_KEY2: key_reg[2] <= cfg_data;
                xbd_pkg::REG_KEY3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Feed the head of the chain
    assign valid_w[0]    = s_tvalid;
    assign s_tready      = ready_w[0];
    assign words_w[0].v0 = s_tdata[31:0];
    assign words_w[0].v1 = s_tdata[63:32];

    // Build the chain: even cells update v1, odd cells update v0
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        localparam int unsigned LEFT = ROUNDS - c / 2 - c % 2;
        localparam logic [31:0] SUM  = xbd_pkg::round_sum(LEFT);
        localparam bit          ODD  = (c % 2) == 1;
        localparam logic [xbd_pkg::KEY_IDX_W-1:0] KSEL = ODD ? SUM[1:0] : SUM[12:11];

        xbd_cell #(
            .SUM       (SUM),
            .UPDATE_V0 (ODD)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[c]),
            .in_ready  (ready_w[c]),
            .in_words  (words_w[c]),
            .key_word  (key_reg[KSEL]),
            .out_valid (valid_w[c+1]),
            .out_ready (ready_w[c+1]),
            .out_words (words_w[c+1])
        );

        assign cell_valid[c] = valid_w[c+1];
    end

    // Drive the result side from the last cell
    assign ready_w[CELLS] = m_tready;
    assign m_tvalid       = valid_w[CELLS];
    assign m_tdata        = {words_w[CELLS].v1, words_w[CELLS].v0};

    // A taken output frees room all the way to the input
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // An empty output cell leaves the whole chain ready
    a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output cell");

    // Back-pressure at the input only when every cell is full
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&cell_valid))
        else $error("input stalled with a bubble in the chain");

endmodule
